>>> rtl/jse_pkg.sv
// Shared types and constants for the JSON string escaper.
// No dependencies; imported by the front, queue and back modules.
`timescale 1ns / 1ps

package jse_pkg;

    localparam logic [7:0] C_BSLASH = 8'h5c;
    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_CTL_HI = 8'h1f;
    localparam logic [7:0] C_PFX0   = 8'he2;
    localparam logic [7:0] C_PFX1   = 8'h80;
    localparam logic [7:0] C_LS     = 8'ha8;
    localparam logic [7:0] C_PS     = 8'ha9;
    localparam logic [7:0] C_CHR_U  = 8'h75;   // 'u'
    localparam logic [7:0] C_CHR_0  = 8'h30;   // '0'
    localparam logic [7:0] C_CHR_2  = 8'h32;   // '2'
    localparam logic [7:0] C_CHR_8  = 8'h38;   // '8'
    localparam logic [7:0] C_CHR_9  = 8'h39;   // '9'
    localparam logic [7:0] C_CHR_A  = 8'h61;   // 'a'

    localparam int MAX_OUT = 8;
    localparam int IDX_W   = $clog2(MAX_OUT);
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [2:0] {
        K_NONE,
        K_RAW,
        K_ESC2,
        K_HEX6,
        K_U20
    } t_kind;

    // one classified input transaction
    typedef struct packed {
        logic [1:0] lead;     // raw prefix bytes from a broken match
        t_kind      kind;
        logic [7:0] body;     // raw byte, escape letter, source byte or final digit
        logic [1:0] tail;     // prefix bytes flushed at end of string
        logic       str_end;
    } t_cmd;

endpackage

>>> rtl/jse_in_if.sv
// Input channel: one raw string byte per transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface jse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_end;

    modport source (output valid, output in_byte, output string_end, input ready);
    modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

>>> rtl/jse_out_if.sv
// Output channel: one escaped text byte per transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface jse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;

    modport source (output valid, output out_byte, output run_last, output text_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input text_end,
                    output ready);
endinterface

>>> rtl/jse_front.sv
// Front end: accepts input bytes, tracks the held E2 / E2 80 prefix and
// classifies each byte into a command. Depends on jse_pkg, jse_in_if.
`timescale 1ns / 1ps

module jse_front
    import jse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    jse_in_if.sink   i_in,
    input  logic     i_q_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic [1:0] r_held;
    logic [1:0] n_held;
    logic [1:0] held_mid;
    logic       fresh;
    logic       fire;
    logic [7:0] b;
    t_cmd       cmd;

    assign b       = i_in.in_byte;
    assign i_in.ready = !i_q_full;
    assign fire    = i_in.valid && i_in.ready;

    always_comb begin
        cmd          = '0;
        cmd.kind     = K_NONE;
        cmd.str_end  = i_in.string_end;
        fresh        = 1'b1;
        held_mid     = 2'd0;
        case (r_held)
            2'd2: begin
                if (b == C_LS || b == C_PS) begin
                    cmd.kind = K_U20;
                    cmd.body = (b == C_LS) ? C_CHR_8 : C_CHR_9;
                    fresh    = 1'b0;
                end else begin
                    cmd.lead = 2'd2;
                end
            end
            2'd1: begin
                if (b == C_PFX1) begin
                    held_mid = 2'd2;
                    fresh    = 1'b0;
                end else begin
                    cmd.lead = 2'd1;
                end
            end
            default: ;
        endcase

        if (fresh) begin
            cmd.body = b;
            if (b == C_PFX0) begin
                held_mid = 2'd1;
            end else begin
                case (b)
                    C_BSLASH, C_QUOTE: cmd.kind = K_ESC2;
                    8'h08: begin cmd.kind = K_ESC2; cmd.body = 8'h62; end
                    8'h0c: begin cmd.kind = K_ESC2; cmd.body = 8'h66; end
                    8'h0a: begin cmd.kind = K_ESC2; cmd.body = 8'h6e; end
                    8'h0d: begin cmd.kind = K_ESC2; cmd.body = 8'h72; end
                    8'h09: begin cmd.kind = K_ESC2; cmd.body = 8'h74; end
                    default: cmd.kind = (b <= C_CTL_HI) ? K_HEX6 : K_RAW;
                endcase
            end
        end

        if (i_in.string_end) begin
            cmd.tail = held_mid;
            n_held   = 2'd0;
        end else begin
            n_held   = held_mid;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = fire && (cmd.lead != 2'd0 || cmd.kind != K_NONE || cmd.tail != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 2'd0;
        end else if (fire) begin
            r_held <= n_held;
        end
    end

endmodule

>>> rtl/jse_fifo.sv
// Two-entry command queue between the front and back ends.
// Depends on jse_pkg.
`timescale 1ns / 1ps

module jse_fifo
    import jse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_cmd                r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]    r_wr;
    logic [PTR_W-1:0]    r_rd;
    logic [PTR_W:0]      r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/jse_back.sv
// Back end: expands one queued command into its escaped byte run and
// sends the bytes one per cycle while o_out is ready. Depends on jse_pkg, jse_out_if.
`timescale 1ns / 1ps

module jse_back
    import jse_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    jse_out_if.source o_out
);

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (C_CHR_0 + {4'd0, nib})
                                 : (C_CHR_A + {4'd0, nib} - 8'd10);
    endfunction

    logic [7:0]       r_buf [MAX_OUT];
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_last;
    logic             r_end;
    logic             r_busy;

    logic [7:0]       body [MAX_OUT];
    logic [IDX_W:0]   blen;
    logic [7:0]       expd [MAX_OUT];
    logic [IDX_W:0]   tot;
    logic [IDX_W:0]   kk;
    logic [IDX_W:0]   j;
    logic [IDX_W:0]   t;
    logic             at_last;
    logic             load;

    always_comb begin
        for (int k = 0; k < MAX_OUT; k++) begin
            body[k] = 8'h00;
        end
        blen = '0;
        case (i_cmd.kind)
            K_RAW: begin
                body[0] = i_cmd.body;
                blen    = (IDX_W+1)'(1);
            end
            K_ESC2: begin
                body[0] = C_BSLASH;
                body[1] = i_cmd.body;
                blen    = (IDX_W+1)'(2);
            end
            K_HEX6: begin
                body[0] = C_BSLASH;
                body[1] = C_CHR_U;
                body[2] = C_CHR_0;
                body[3] = C_CHR_0;
                body[4] = hex_char(i_cmd.body[7:4]);
                body[5] = hex_char(i_cmd.body[3:0]);
                blen    = (IDX_W+1)'(6);
            end
            K_U20: begin
                body[0] = C_BSLASH;
                body[1] = C_CHR_U;
                body[2] = C_CHR_2;
                body[3] = C_CHR_0;
                body[4] = C_CHR_2;
                body[5] = i_cmd.body;
                blen    = (IDX_W+1)'(6);
            end
            default: ;
        endcase

        for (int k = 0; k < MAX_OUT; k++) begin
            kk = (IDX_W+1)'(k);
            j  = kk - (IDX_W+1)'(i_cmd.lead);
            t  = j - blen;
            if (kk < (IDX_W+1)'(i_cmd.lead)) begin
                expd[k] = (kk == '0) ? C_PFX0 : C_PFX1;
            end else if (j < blen) begin
                expd[k] = body[j[IDX_W-1:0]];
            end else begin
                expd[k] = (t == '0) ? C_PFX0 : C_PFX1;
            end
        end

        tot = (IDX_W+1)'(i_cmd.lead) + blen + (IDX_W+1)'(i_cmd.tail);
    end

    assign at_last = (r_idx == r_last);
    assign load    = !i_q_empty && (!r_busy || (o_out.ready && at_last));
    assign o_pop   = load;

    assign o_out.valid    = r_busy;
    assign o_out.out_byte = r_buf[r_idx];
    assign o_out.run_last = at_last;
    assign o_out.text_end = at_last && r_end;

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < MAX_OUT; k++) begin
                r_buf[k] <= expd[k];
            end
            r_last <= IDX_W'(tot - 1'b1);
            r_end  <= i_cmd.str_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && o_out.ready) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

endmodule

>>> rtl/json_string_escaper_core.sv
// JSON string escaper, top level: front classifier, command queue, back expander.
// Depends on jse_pkg, jse_in_if, jse_out_if, jse_front, jse_fifo, jse_back.
//
// Usage:
//   i_in carries one raw UTF-8 byte per transaction with string_end set on the
//   string's final byte. o_out carries the escaped text, one byte per
//   transaction; run_last marks the last byte caused by one input byte and
//   text_end the final byte of the string.
//   A command passes through the command queue and the back-end run buffer.
//   Throughput: one input per cycle while o_out is ready and each byte maps to
//   one output byte; an input that expands to N bytes (up to 8) keeps the back
//   end busy until they are sent, and the 2-entry command queue then fills and
//   holds off i_in. Bytes E2 and E2 80 are held in the front end and produce no
//   transaction until the next byte or end of string decides them.
//   Reset (synchronous, active low) empties the queue, drops any held prefix
//   and any partly sent run. A stall on o_out freezes the current byte; the
//   front keeps accepting until the queue is full.
`timescale 1ns / 1ps

module json_string_escaper_core
    import jse_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    jse_in_if.sink    i_in,
    jse_out_if.source o_out
);

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    t_cmd cmd_in;
    t_cmd cmd_out;

    jse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (cmd_in)
    );

    jse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (cmd_out)
    );

    jse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (cmd_out),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

>>> tb/tb_json_string_escaper_core.sv
// Self-checking testbench for json_string_escaper_core: directed table, then random strings.
// Depends on jse_pkg, jse_in_if, jse_out_if and the escaper RTL; needs nothing else.
`timescale 1ns / 1ps

module tb_json_string_escaper_core
    import jse_pkg::*;
();

    localparam int N_ITEMS    = 480;
    localparam int QUIET_TAIL = 64;
    localparam int DRAIN      = 24;
    localparam int LIMIT      = 300000;

    localparam logic [1:0] HOLD_NONE  = 2'd0;
    localparam logic [1:0] HOLD_E2    = 2'd1;
    localparam logic [1:0] HOLD_E2_80 = 2'd2;

    // one input transaction; typed rows carry their escaped text in txt
    typedef struct packed {
        logic [7:0]  b;
        logic        e;
        logic        typed;
        logic [3:0]  n;
        logic [63:0] txt;
    } t_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       tend;
    } t_out;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jse_in_if  in_ch();
    jse_out_if out_ch();

    json_string_escaper_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_item dir_tab [26] = '{
        '{8'h41, 1'b1, 1'b1, 4'd1, "A"},
        '{8'h00, 1'b0, 1'b1, 4'd6, "\\u0000"},
        '{8'h1f, 1'b0, 1'b1, 4'd6, "\\u001f"},
        '{8'h5c, 1'b0, 1'b1, 4'd2, "\\\\"},
        '{8'h22, 1'b0, 1'b1, 4'd2, "\\\""},
        '{8'h08, 1'b0, 1'b1, 4'd2, "\\b"},
        '{8'h0c, 1'b0, 1'b1, 4'd2, "\\f"},
        '{8'h0a, 1'b0, 1'b1, 4'd2, "\\n"},
        '{8'h0d, 1'b0, 1'b1, 4'd2, "\\r"},
        '{8'h09, 1'b1, 1'b1, 4'd2, "\\t"},
        '{8'hff, 1'b1, 1'b0, 4'd0, 64'd0},
        '{8'he2, 1'b0, 1'b1, 4'd0, 64'd0},
        '{8'h80, 1'b0, 1'b1, 4'd0, 64'd0},
        '{8'ha8, 1'b0, 1'b1, 4'd6, "\\u2028"},
        '{8'he2, 1'b0, 1'b1, 4'd0, 64'd0},
        '{8'h80, 1'b0, 1'b1, 4'd0, 64'd0},
        '{8'ha9, 1'b1, 1'b1, 4'd6, "\\u2029"},
        '{8'he2, 1'b0, 1'b1, 4'd0, 64'd0},
        '{8'h41, 1'b0, 1'b0, 4'd0, 64'd0},
        '{8'he2, 1'b0, 1'b1, 4'd0, 64'd0},
        '{8'h80, 1'b0, 1'b1, 4'd0, 64'd0},
        '{8'he2, 1'b0, 1'b0, 4'd0, 64'd0},
        '{8'h0a, 1'b1, 1'b0, 4'd0, 64'd0},
        '{8'he2, 1'b1, 1'b0, 4'd0, 64'd0},
        '{8'he2, 1'b0, 1'b1, 4'd0, 64'd0},
        '{8'h80, 1'b1, 1'b0, 4'd0, 64'd0}
    };

    t_item      byte_q [$];
    t_out       escaped_q [$];
    logic [7:0] run_bytes [$];
    logic [1:0] held = HOLD_NONE;
    int         mismatches = 0;
    int         in_gap = 0;
    int         out_gap = 0;
    int         cycles = 0;

    function automatic void add_byte(logic [7:0] b);
        byte_q.insert(byte_q.size(), t_item'{b, 1'b0, 1'b0, 4'd0, 64'd0});
    endfunction

    function automatic void emit(logic [7:0] c);
        run_bytes.insert(run_bytes.size(), c);
    endfunction

    function automatic void put_escaped(logic [7:0] b);
        logic [7:0] two;
        logic [3:0] nib;
        case (b)
            C_BSLASH: two = C_BSLASH;
            C_QUOTE:  two = C_QUOTE;
            8'h08:    two = "b";
            8'h0c:    two = "f";
            8'h0a:    two = "n";
            8'h0d:    two = "r";
            8'h09:    two = "t";
            default:  two = 8'h00;
        endcase
        if (two != 8'h00) begin
            emit(C_BSLASH);
            emit(two);
        end else if (b <= C_CTL_HI) begin
            emit(C_BSLASH);
            emit(C_CHR_U);
            emit(C_CHR_0);
            emit(C_CHR_0);
            for (int k = 1; k >= 0; k--) begin
                nib = b[4*k +: 4];
                emit(nib < 4'd10 ? C_CHR_0 + {4'd0, nib}
                                 : C_CHR_A + {4'd0, nib} - 8'd10);
            end
        end else begin
            emit(b);
        end
    endfunction

    // escaped bytes for one input byte; advances the held-prefix count
    function automatic void escape_step(logic [7:0] b, logic e);
        logic fresh;
        fresh = 1'b1;
        run_bytes.delete();
        if (held == HOLD_E2_80) begin
            held = HOLD_NONE;
            if (b == C_LS || b == C_PS) begin
                emit(C_BSLASH);
                emit(C_CHR_U);
                emit(C_CHR_2);
                emit(C_CHR_0);
                emit(C_CHR_2);
                emit(b == C_LS ? C_CHR_8 : C_CHR_9);
                fresh = 1'b0;
            end else begin
                emit(C_PFX0);
                emit(C_PFX1);
            end
        end else if (held == HOLD_E2) begin
            if (b == C_PFX1) begin
                held = HOLD_E2_80;
                fresh = 1'b0;
            end else begin
                held = HOLD_NONE;
                emit(C_PFX0);
            end
        end else begin
            held = HOLD_NONE;
        end
        if (fresh) begin
            if (b == C_PFX0)
                held = HOLD_E2;
            else
                put_escaped(b);
        end
        if (e) begin
            if (held == HOLD_E2 || held == HOLD_E2_80)
                emit(C_PFX0);
            if (held == HOLD_E2_80)
                emit(C_PFX1);
            held = HOLD_NONE;
        end
    endfunction

    function automatic void log_accepted(t_item it);
        int cnt;
        escape_step(it.b, it.e);
        if (it.typed) begin
            run_bytes.delete();
            for (int k = 0; k < it.n; k++)
                emit(it.txt[8*(it.n-1-k) +: 8]);
        end
        cnt = run_bytes.size();
        for (int k = 0; k < cnt; k++)
            escaped_q.insert(escaped_q.size(),
                             t_out'{run_bytes[k], k == cnt - 1, (k == cnt - 1) && it.e});
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0d: %s", cycles, msg);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                log_accepted(byte_q[0]);
                void'(byte_q.pop_front());
            end
            if (in_ch.valid && !in_ch.ready) begin
            end else if (in_gap > 0) begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
                if (byte_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                    in_gap = $urandom_range(0, 6);
                    in_ch.valid <= 1'b0;
                end else begin
                    in_ch.valid      <= 1'b1;
                    in_ch.in_byte    <= byte_q[0].b;
                    in_ch.string_end <= byte_q[0].e;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out exp_o;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (escaped_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected transaction byte=%h run_last=%b text_end=%b",
                                            out_ch.out_byte, out_ch.run_last, out_ch.text_end));
                end else begin
                    exp_o = escaped_q.pop_front();
                    if (out_ch.out_byte !== exp_o.ch || out_ch.run_last !== exp_o.last ||
                        out_ch.text_end !== exp_o.tend)
                        note_mismatch($sformatf(
                            "exp byte=%h run_last=%b text_end=%b got byte=%h run_last=%b text_end=%b",
                            exp_o.ch, exp_o.last, exp_o.tend,
                            out_ch.out_byte, out_ch.run_last, out_ch.text_end));
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end else if (byte_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                out_gap = $urandom_range(0, 6);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_item it;
        int    len;
        int    piece;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.in_byte    = 8'h00;
        in_ch.string_end = 1'b0;
        out_ch.ready     = 1'b0;

        foreach (dir_tab[i])
            byte_q.insert(byte_q.size(), dir_tab[i]);

        // random strings, mostly built from escape-relevant pieces
        while (byte_q.size() < N_ITEMS) begin
            len = $urandom_range(1, 8);
            for (int p = 0; p < len; p++) begin
                piece = $urandom_range(0, 9);
                case (piece)
                    0, 1: begin
                        add_byte(C_PFX0);
                        add_byte(C_PFX1);
                        add_byte($urandom_range(0, 1) ? C_LS : C_PS);
                    end
                    2: begin
                        add_byte(C_PFX0);
                        if ($urandom_range(0, 1))
                            add_byte(C_PFX1);
                    end
                    3: add_byte($urandom_range(0, 1) ? C_BSLASH : C_QUOTE);
                    4: add_byte(8'($urandom_range(0, 31)));
                    default: add_byte(8'($urandom_range(0, 255)));
                endcase
            end
            it = byte_q.pop_back();
            it.e = 1'b1;
            byte_q.insert(byte_q.size(), it);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || in_ch.valid)
            @(posedge i_clk);
        while (escaped_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (mismatches == 0 && escaped_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
rtl/jse_pkg.sv
rtl/jse_in_if.sv
rtl/jse_out_if.sv
rtl/jse_front.sv
rtl/jse_fifo.sv
rtl/jse_back.sv
rtl/json_string_escaper_core.sv
tb/tb_json_string_escaper_core.sv
